### sv/register_command_frame_engine_top_macros.svh
// assertion macros for the register command frame engine checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef REGISTER_COMMAND_FRAME_ENGINE_TOP_MACROS_SVH
`define REGISTER_COMMAND_FRAME_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define RCFE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rcfe check failed");

// next-cycle implication
`define RCFE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rcfe check failed");

`endif

### sv/rcfe_pkg.sv
// shared constants, item types and control/status structs for the frame engine
// no dependencies
package rcfe_pkg;

  localparam int REG_COUNT       = 128;
  localparam int LOG_DEPTH       = 16;
  localparam int SENSOR_CHANNELS = 8;

  localparam int RF_AW  = $clog2(REG_COUNT);
  localparam int LOG_AW = $clog2(LOG_DEPTH);
  localparam int LOG_CW = $clog2(LOG_DEPTH + 1);
  localparam int PAY_W  = $clog2(2 * LOG_DEPTH + 1);

  localparam logic [7:0] READ_FLAG = 8'h80;
  localparam logic [7:0] IDX_VOLT  = 8'h10;
  localparam logic [7:0] IDX_CURR  = 8'h11;
  localparam logic [7:0] HDR_N     = 8'h4E;
  localparam logic [7:0] HDR_R     = 8'h52;
  localparam logic [7:0] HDR_VER   = 8'h02;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_VOLT  = 2'd1,
    OP_CURR  = 2'd2,
    OP_REPLY = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    EMIT_NONE,
    EMIT_N,
    EMIT_R,
    EMIT_VER,
    EMIT_LEN,
    EMIT_IDX,
    EMIT_CHAN,
    EMIT_DATA,
    EMIT_SHI,
    EMIT_SLO
  } emit_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic        frame_start;
    logic [2:0]  sensor_channel;
    logic [15:0] sensor_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_valid;
    logic       reply_last;
    logic       heartbeat;
    logic       write_strobe;
    logic [6:0] write_index;
    logic [7:0] write_value;
  } out_item_t;

  typedef struct packed {
    logic  accept;
    logic  walk_start;
    emit_e emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_reply;
    logic log_empty;
    logic walk_multi;
    logic ent_sensor;
    logic last_entry;
    logic walk_done;
  } dp_status_t;

endpackage

### sv/rcfe_in_if.sv
// input item channel: valid/ready handshake with an rcfe_pkg::in_item_t payload
// depends on rcfe_pkg
interface rcfe_in_if;
  logic                 valid;
  logic                 ready;
  rcfe_pkg::in_item_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/rcfe_out_if.sv
// result item channel: valid/ready handshake with an rcfe_pkg::out_item_t payload
// depends on rcfe_pkg
interface rcfe_out_if;
  logic                 valid;
  logic                 ready;
  rcfe_pkg::out_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/register_command_frame_engine_top.sv
// Register command frame engine, top level.
// Input channel in_i carries frame bytes, sensor updates and reply requests;
// output channel out_o carries write strobes, heartbeats and reply bytes.
// A frame byte that writes a register gives its strobe item in the cycle after
// it is accepted. A sensor update or any other frame byte gives no item.
// A reply request with an empty log gives a heartbeat item in the next cycle.
// Otherwise the reply walk starts: 'N' passes the ST_HDR_N state and then the
// single output register that the walk loads, then one byte per cycle while
// the receiver takes them (4 + payload length bytes, at most 4 + 2 * depth).
// Items that give at most one result are taken one per cycle while the
// output register is free or being drained; a reply holds the input for the
// whole walk. A register read during the walk is a registered read of the
// register file memory, hidden behind the index byte.
// When the receiver stalls, the output item holds and input is not taken.
// Reset clears the parser, log count, sensor stores, register file valid
// bits and the output valid flag; it takes effect at once, with no sweep.
// depends on rcfe_pkg, rcfe_in_if, rcfe_out_if, rcfe_ctrl, rcfe_dpath
module register_command_frame_engine_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  rcfe_in_if.sink    in_i,
  rcfe_out_if.source out_o
);

  rcfe_pkg::ctrl_cmd_t  cmd;
  rcfe_pkg::dp_status_t status;
  logic                 in_ready;

  rcfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  rcfe_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_i.payload),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.payload)
  );

  assign in_i.ready = in_ready;

endmodule

### sv/rcfe_ctrl.sv
// controller: input acceptance and the reply walk sequence
// depends on rcfe_pkg
module rcfe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  rcfe_pkg::dp_status_t status_i,
  output logic                 in_ready_o,
  output rcfe_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR_N,
    ST_HDR_R,
    ST_HDR_VER,
    ST_HDR_LEN,
    ST_ENTRY,
    ST_DATA,
    ST_SHI,
    ST_SLO
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.emit = rcfe_pkg::EMIT_NONE;
    in_ready_o = (state_q == ST_IDLE) && status_i.out_free;
    cmd_o.accept = in_valid_i && in_ready_o;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept && status_i.is_reply && !status_i.log_empty) begin
          cmd_o.walk_start = 1'b1;
          state_d          = ST_HDR_N;
        end
      end
      ST_HDR_N: begin
        if (status_i.out_free) begin
          cmd_o.emit = rcfe_pkg::EMIT_N;
          state_d    = ST_HDR_R;
        end
      end
      ST_HDR_R: begin
        if (status_i.out_free) begin
          cmd_o.emit = rcfe_pkg::EMIT_R;
          state_d    = ST_HDR_VER;
        end
      end
      ST_HDR_VER: begin
        if (status_i.out_free) begin
          cmd_o.emit = rcfe_pkg::EMIT_VER;
          state_d    = ST_HDR_LEN;
        end
      end
      ST_HDR_LEN: begin
        if (status_i.out_free) begin
          cmd_o.emit = rcfe_pkg::EMIT_LEN;
          state_d    = ST_ENTRY;
        end
      end
      ST_ENTRY: begin
        if (status_i.out_free) begin
          if (status_i.walk_multi) begin
            cmd_o.emit = rcfe_pkg::EMIT_CHAN;
            state_d    = ST_SHI;
          end else if (status_i.ent_sensor) begin
            cmd_o.emit = rcfe_pkg::EMIT_IDX;
            state_d    = status_i.last_entry ? ST_IDLE : ST_ENTRY;
          end else begin
            cmd_o.emit = rcfe_pkg::EMIT_IDX;
            state_d    = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (status_i.out_free) begin
          cmd_o.emit = rcfe_pkg::EMIT_DATA;
          state_d    = status_i.walk_done ? ST_IDLE : ST_ENTRY;
        end
      end
      ST_SHI: begin
        if (status_i.out_free) begin
          cmd_o.emit = rcfe_pkg::EMIT_SHI;
          state_d    = ST_SLO;
        end
      end
      ST_SLO: begin
        if (status_i.out_free) begin
          cmd_o.emit = rcfe_pkg::EMIT_SLO;
          state_d    = status_i.walk_done ? ST_IDLE : ST_ENTRY;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/rcfe_dpath.sv
// datapath: frame parser, register file, request log, sensor stores, reply bytes
// and the output register; depends on rcfe_pkg
module rcfe_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rcfe_pkg::in_item_t   in_item_i,
  input  logic                 out_ready_i,
  input  rcfe_pkg::ctrl_cmd_t  cmd_i,
  output rcfe_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  output rcfe_pkg::out_item_t  out_item_o
);

  localparam int SC = rcfe_pkg::SENSOR_CHANNELS;
  localparam int CW = rcfe_pkg::LOG_CW;
  localparam int PW = rcfe_pkg::PAY_W;
  localparam int AW = rcfe_pkg::RF_AW;
  localparam logic [7:0]    RegCountB = 8'(rcfe_pkg::REG_COUNT);
  localparam logic [CW-1:0] LogDepthC = CW'(rcfe_pkg::LOG_DEPTH);

  function automatic logic is_sensor(input logic [7:0] v);
    return (v == rcfe_pkg::IDX_VOLT) || (v == rcfe_pkg::IDX_CURR);
  endfunction

  // frame parser state
  logic [7:0]    bytes_left_q;
  logic          expect_q;
  logic          pread_q;
  logic [6:0]    pidx_q;
  logic [CW-1:0] log_count_q;
  logic [PW-1:0] pay_len_q;
  logic          push_multi_q;

  // reply walk state
  logic [CW-1:0] walk_ptr_q;
  logic          walk_multi_q;
  logic          cmd_volt_q;
  logic [15:0]   sval_q;

  // stores
  logic [rcfe_pkg::REG_COUNT-1:0] rf_vld_q;
  logic [7:0]  rf_mem [rcfe_pkg::REG_COUNT];
  logic [7:0]  rf_rdata_q;
  logic        rf_rok_q;
  logic [7:0]  log_mem [rcfe_pkg::LOG_DEPTH];
  logic [15:0] volt_q [SC];
  logic [15:0] cur_q [SC];

  logic                out_valid_q;
  rcfe_pkg::out_item_t out_q, out_d;

  logic          fr_acc, fr_body, fr_cmd, fr_val, rf_we;
  logic          push_en, do_push;
  logic [7:0]    push_val;
  logic [PW-1:0] push_add;
  logic [7:0]    ent;
  logic [15:0]   sens_sel;
  logic          hb_load, walk_load;
  logic [7:0]    walk_byte;
  logic          walk_last;

  assign fr_acc  = cmd_i.accept && (in_item_i.operation == rcfe_pkg::OP_FRAME);
  assign fr_body = fr_acc && !in_item_i.frame_start && (bytes_left_q != 8'd0);
  assign fr_cmd  = fr_body && !expect_q;
  assign fr_val  = fr_body && expect_q;
  assign rf_we   = fr_val && !pread_q && ({1'b0, pidx_q} < RegCountB);

  always_comb begin
    push_en  = 1'b0;
    push_val = in_item_i.data_byte;
    if (fr_cmd && ((in_item_i.data_byte & rcfe_pkg::READ_FLAG) != 8'd0)) begin
      push_en  = 1'b1;
      push_val = {1'b0, in_item_i.data_byte[6:0]};
    end else if (fr_val && pread_q && is_sensor({1'b0, pidx_q})) begin
      push_en  = 1'b1;
    end
  end

  assign do_push = push_en && (log_count_q != LogDepthC);

  // payload length grows with each logged entry
  always_comb begin
    if (push_multi_q) begin
      push_add = PW'(3);
    end else if (is_sensor(push_val)) begin
      push_add = PW'(1);
    end else begin
      push_add = PW'(2);
    end
  end

  assign ent = log_mem[walk_ptr_q[rcfe_pkg::LOG_AW-1:0]];

  always_comb begin
    sens_sel = 16'd0;
    for (int i = 0; i < SC; i++) begin
      if (ent == 8'(i)) begin
        sens_sel = cmd_volt_q ? volt_q[i] : cur_q[i];
      end
    end
  end

  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.is_reply   = (in_item_i.operation == rcfe_pkg::OP_REPLY);
  assign status_o.log_empty  = (log_count_q == '0);
  assign status_o.walk_multi = walk_multi_q;
  assign status_o.ent_sensor = is_sensor(ent);
  assign status_o.last_entry = ((walk_ptr_q + CW'(1)) == log_count_q);
  assign status_o.walk_done  = (walk_ptr_q == log_count_q);

  always_comb begin
    walk_last = 1'b0;
    case (cmd_i.emit)
      rcfe_pkg::EMIT_N:    walk_byte = rcfe_pkg::HDR_N;
      rcfe_pkg::EMIT_R:    walk_byte = rcfe_pkg::HDR_R;
      rcfe_pkg::EMIT_VER:  walk_byte = rcfe_pkg::HDR_VER;
      rcfe_pkg::EMIT_LEN:  walk_byte = 8'(pay_len_q);
      rcfe_pkg::EMIT_IDX: begin
        walk_byte = ent;
        walk_last = is_sensor(ent) && status_o.last_entry;
      end
      rcfe_pkg::EMIT_CHAN: walk_byte = ent;
      rcfe_pkg::EMIT_DATA: begin
        walk_byte = rf_rok_q ? rf_rdata_q : 8'd0;
        walk_last = status_o.walk_done;
      end
      rcfe_pkg::EMIT_SHI:  walk_byte = sval_q[15:8];
      rcfe_pkg::EMIT_SLO: begin
        walk_byte = sval_q[7:0];
        walk_last = status_o.walk_done;
      end
      default:             walk_byte = 8'd0;
    endcase
  end

  assign walk_load = (cmd_i.emit != rcfe_pkg::EMIT_NONE);
  assign hb_load   = cmd_i.accept && status_o.is_reply && status_o.log_empty;

  always_comb begin
    out_d = '0;
    if (walk_load) begin
      out_d.reply_byte  = walk_byte;
      out_d.reply_valid = 1'b1;
      out_d.reply_last  = walk_last;
    end else if (hb_load) begin
      out_d.heartbeat = 1'b1;
    end else if (rf_we) begin
      out_d.write_strobe = 1'b1;
      out_d.write_index  = pidx_q;
      out_d.write_value  = in_item_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= 8'd0;
      expect_q     <= 1'b0;
      pread_q      <= 1'b0;
      pidx_q       <= 7'd0;
      log_count_q  <= '0;
      pay_len_q    <= '0;
      push_multi_q <= 1'b0;
      walk_ptr_q   <= '0;
      walk_multi_q <= 1'b0;
      cmd_volt_q   <= 1'b0;
      rf_vld_q     <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < SC; i++) begin
        volt_q[i] <= 16'd0;
        cur_q[i]  <= 16'd0;
      end
    end else begin
      if (fr_acc && in_item_i.frame_start) begin
        bytes_left_q <= in_item_i.data_byte;
        expect_q     <= 1'b0;
        pread_q      <= 1'b0;
        pidx_q       <= 7'd0;
        log_count_q  <= '0;
        pay_len_q    <= '0;
        push_multi_q <= 1'b0;
      end else if (fr_body) begin
        bytes_left_q <= bytes_left_q - 8'd1;
        expect_q     <= !expect_q;
        if (fr_cmd) begin
          pidx_q  <= in_item_i.data_byte[6:0];
          pread_q <= in_item_i.data_byte[7];
        end
        if (do_push) begin
          log_count_q  <= log_count_q + CW'(1);
          pay_len_q    <= pay_len_q + push_add;
          push_multi_q <= !push_multi_q && is_sensor(push_val);
        end
      end
      if (rf_we) begin
        rf_vld_q[pidx_q[AW-1:0]] <= 1'b1;
      end
      for (int i = 0; i < SC; i++) begin
        if (cmd_i.accept && ({5'd0, in_item_i.sensor_channel} == 8'(i))) begin
          if (in_item_i.operation == rcfe_pkg::OP_VOLT) begin
            volt_q[i] <= in_item_i.sensor_value;
          end
          if (in_item_i.operation == rcfe_pkg::OP_CURR) begin
            cur_q[i] <= in_item_i.sensor_value;
          end
        end
      end
      if (cmd_i.walk_start) begin
        walk_ptr_q   <= '0;
        walk_multi_q <= 1'b0;
      end else if (cmd_i.emit == rcfe_pkg::EMIT_IDX) begin
        walk_ptr_q   <= walk_ptr_q + CW'(1);
        walk_multi_q <= is_sensor(ent);
        cmd_volt_q   <= (ent == rcfe_pkg::IDX_VOLT);
      end else if (cmd_i.emit == rcfe_pkg::EMIT_CHAN) begin
        walk_ptr_q   <= walk_ptr_q + CW'(1);
        walk_multi_q <= 1'b0;
      end
      if (walk_load || hb_load || rf_we) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // memories and payload registers
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[pidx_q[AW-1:0]] <= in_item_i.data_byte;
    end
    if (cmd_i.emit == rcfe_pkg::EMIT_IDX) begin
      rf_rdata_q <= rf_mem[ent[AW-1:0]];
      rf_rok_q   <= (ent < RegCountB) && rf_vld_q[ent[AW-1:0]];
    end
    if (do_push) begin
      log_mem[log_count_q[rcfe_pkg::LOG_AW-1:0]] <= push_val;
    end
    if (cmd_i.emit == rcfe_pkg::EMIT_CHAN) begin
      sval_q <= sens_sel;
    end
    if (walk_load || hb_load || rf_we) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### sv/rcfe_chk.sv
// port-level checker for the frame engine, bound to the top level
// depends on rcfe_pkg, rcfe_in_if, rcfe_out_if and the macro header
`include "register_command_frame_engine_top_macros.svh"

module rcfe_chk (
  input logic        clk_i,
  input logic        rst_ni,
  rcfe_in_if.sink    in_i,
  rcfe_out_if.source out_o
);

  logic [2:0] kind;
  logic       mid_reply;

  assign kind = {out_o.payload.reply_valid, out_o.payload.heartbeat,
                 out_o.payload.write_strobe};
  assign mid_reply = out_o.valid && out_o.payload.reply_valid && !out_o.payload.reply_last;

  // every item is exactly one of reply byte, heartbeat or write strobe
  `RCFE_ASSERT_IMP(a_one_kind, out_o.valid, $onehot(kind))
  // input stays closed while a reply frame is unfinished
  `RCFE_ASSERT_IMP(a_walk_blocks_input, mid_reply, !in_i.ready)
  // stalled item is not dropped
  `RCFE_ASSERT_NXT(a_stall_holds, out_o.valid && !out_o.ready, out_o.valid)

endmodule

bind register_command_frame_engine_top rcfe_chk u_rcfe_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

### tb/tb_register_command_frame_engine_top.sv
`timescale 1ns / 100ps
// self-checking bench for the register command frame engine: directed table, then random items
// depends on rcfe_pkg, rcfe_in_if, rcfe_out_if and register_command_frame_engine_top
module tb_register_command_frame_engine_top;

  typedef struct {
    rcfe_pkg::in_item_t  item;
    bit                  typed;
    rcfe_pkg::out_item_t want;
  } stim_row_t;

  localparam rcfe_pkg::out_item_t HB_OUT = '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 7'h00, 8'h00};
  localparam rcfe_pkg::out_item_t NO_OUT = '0;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 125;
  localparam int LAW = rcfe_pkg::LOG_AW;
  localparam int SCW = $clog2(rcfe_pkg::SENSOR_CHANNELS);

  logic clk_i;
  logic rst_ni;

  rcfe_in_if  in_ch ();
  rcfe_out_if out_ch ();

  register_command_frame_engine_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // shadow copy of the engine state
  logic [7:0]  model_regs [rcfe_pkg::REG_COUNT]       = '{default: 8'h00};
  logic [7:0]  model_log  [rcfe_pkg::LOG_DEPTH]       = '{default: 8'h00};
  logic [15:0] model_volt [rcfe_pkg::SENSOR_CHANNELS] = '{default: 16'h0000};
  logic [15:0] model_curr [rcfe_pkg::SENSOR_CHANNELS] = '{default: 16'h0000};
  int          model_log_n    = 0;
  logic [7:0]  model_left     = 8'h00;
  bit          model_want_val = 1'b0;
  bit          model_rd_pend  = 1'b0;
  logic [6:0]  model_idx      = 7'h00;

  rcfe_pkg::out_item_t due_outputs[$];
  int        err_count    = 0;
  int        items_in     = 0;
  int        items_out    = 0;
  int        strobes_seen = 0;
  int        beats_seen   = 0;
  int        replies_seen = 0;
  bit        idling_on    = 1'b1;
  bit        long_hold_req = 1'b0;

  // extremes, ignored bytes, out-of-range channel, lone sensor index, repeated reply
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{rcfe_pkg::OP_REPLY, 8'h00, 1'b0, 3'd0, 16'h0000}, 1'b1, HB_OUT},
    '{'{rcfe_pkg::OP_FRAME, 8'hFF, 1'b0, 3'd7, 16'hFFFF}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_VOLT,  8'h00, 1'b0, 3'd7, 16'hFFFF}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_CURR,  8'hFF, 1'b1, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_CURR,  8'h00, 1'b0, 3'd7, 16'h8001}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_FRAME, 8'hFF, 1'b1, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_FRAME, 8'h7F, 1'b0, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_FRAME, 8'hFF, 1'b0, 3'd0, 16'h0000}, 1'b1,
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 7'h7F, 8'hFF}},
    '{'{rcfe_pkg::OP_FRAME, 8'h00, 1'b0, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_FRAME, 8'h00, 1'b0, 3'd0, 16'h0000}, 1'b1,
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 7'h00, 8'h00}},
    '{'{rcfe_pkg::OP_FRAME, 8'hFF, 1'b0, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_FRAME, 8'hAA, 1'b0, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_FRAME, 8'h90, 1'b0, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_FRAME, 8'h07, 1'b0, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_FRAME, 8'h91, 1'b0, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_FRAME, 8'h07, 1'b0, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_FRAME, 8'h91, 1'b0, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_FRAME, 8'h0C, 1'b0, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_REPLY, 8'h55, 1'b1, 3'd5, 16'h1234}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_REPLY, 8'h00, 1'b0, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_FRAME, 8'h01, 1'b1, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_FRAME, 8'h90, 1'b0, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_REPLY, 8'h00, 1'b0, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_FRAME, 8'h00, 1'b1, 3'd0, 16'h0000}, 1'b0, NO_OUT},
    '{'{rcfe_pkg::OP_REPLY, 8'h00, 1'b0, 3'd0, 16'h0000}, 1'b1, HB_OUT}
  };

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("timeout with %0d items still due", due_outputs.size());
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  function automatic void log_request(input logic [7:0] v);
    if (model_log_n < rcfe_pkg::LOG_DEPTH) begin
      model_log[LAW'(model_log_n)] = v;
      model_log_n++;
    end
  endfunction

  function automatic logic [15:0] sensor_reading(input bit is_volt, input logic [7:0] ch);
    if (ch >= rcfe_pkg::SENSOR_CHANNELS) return 16'h0000;
    return is_volt ? model_volt[ch[SCW-1:0]] : model_curr[ch[SCW-1:0]];
  endfunction

  // advance the shadow state by one item and append the items it produces
  function automatic void step_engine_copy(input rcfe_pkg::in_item_t it,
                                           ref rcfe_pkg::out_item_t res[$]);
    rcfe_pkg::out_item_t r;
    logic [7:0]  pay[$];
    logic [7:0]  e;
    logic [7:0]  cmd;
    logic [15:0] s;
    bit          multi;
    int          total;
    r = '0;
    cmd = 8'h00;
    multi = 1'b0;
    case (rcfe_pkg::op_e'(it.operation))
      rcfe_pkg::OP_FRAME: begin
        if (it.frame_start) begin
          model_log_n    = 0;
          model_left     = it.data_byte;
          model_want_val = 1'b0;
          model_rd_pend  = 1'b0;
          model_idx      = 7'h00;
        end else if (model_left != 8'h00) begin
          model_left--;
          if (!model_want_val) begin
            model_idx = it.data_byte[6:0];
            model_rd_pend = (it.data_byte & rcfe_pkg::READ_FLAG) != 8'h00;
            if (model_rd_pend) log_request({1'b0, model_idx});
            model_want_val = 1'b1;
          end else begin
            model_want_val = 1'b0;
            if (!model_rd_pend) begin
              if (model_idx < rcfe_pkg::REG_COUNT) begin
                model_regs[model_idx] = it.data_byte;
                r.write_strobe = 1'b1;
                r.write_index  = model_idx;
                r.write_value  = it.data_byte;
                res.push_back(r);
              end
            end else if ({1'b0, model_idx} == rcfe_pkg::IDX_VOLT ||
                         {1'b0, model_idx} == rcfe_pkg::IDX_CURR) begin
              log_request(it.data_byte);
            end
          end
        end
      end
      rcfe_pkg::OP_VOLT:
        if (it.sensor_channel < rcfe_pkg::SENSOR_CHANNELS)
          model_volt[it.sensor_channel] = it.sensor_value;
      rcfe_pkg::OP_CURR:
        if (it.sensor_channel < rcfe_pkg::SENSOR_CHANNELS)
          model_curr[it.sensor_channel] = it.sensor_value;
      rcfe_pkg::OP_REPLY: begin
        if (model_log_n == 0) begin
          r.heartbeat = 1'b1;
          res.push_back(r);
        end else begin
          for (int i = 0; i < model_log_n; i++) begin
            e = model_log[LAW'(i)];
            if (multi) begin
              multi = 1'b0;
              s = sensor_reading(cmd == rcfe_pkg::IDX_VOLT, e);
              pay.push_back(e);
              pay.push_back(s[15:8]);
              pay.push_back(s[7:0]);
            end else begin
              cmd = e;
              pay.push_back(e);
              if (e == rcfe_pkg::IDX_VOLT || e == rcfe_pkg::IDX_CURR) multi = 1'b1;
              else pay.push_back(e < rcfe_pkg::REG_COUNT ? model_regs[e[6:0]] : 8'h00);
            end
          end
          pay.push_front(8'(pay.size()));
          pay.push_front(rcfe_pkg::HDR_VER);
          pay.push_front(rcfe_pkg::HDR_R);
          pay.push_front(rcfe_pkg::HDR_N);
          total = pay.size();
          for (int i = 0; i < total; i++) begin
            r = '0;
            r.reply_byte  = pay[i];
            r.reply_valid = 1'b1;
            r.reply_last  = (i + 1 == total);
            res.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic offer_item(input rcfe_pkg::in_item_t it, input bit typed,
                            input rcfe_pkg::out_item_t want);
    rcfe_pkg::out_item_t fresh[$];
    while (idling_on && $urandom_range(0, 99) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_in++;
    step_engine_copy(it, fresh);
    if (typed) due_outputs.push_back(want);
    else foreach (fresh[i]) due_outputs.push_back(fresh[i]);
  endtask

  function automatic rcfe_pkg::in_item_t any_fields();
    rcfe_pkg::in_item_t it;
    it.operation      = 2'($urandom_range(0, 3));
    it.data_byte      = 8'($urandom_range(0, 255));
    it.frame_start    = ($urandom_range(0, 7) == 0);
    it.sensor_channel = 3'($urandom_range(0, 7));
    it.sensor_value   = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  function automatic rcfe_pkg::in_item_t frame_item(input logic [7:0] b, input bit st);
    rcfe_pkg::in_item_t it;
    it = any_fields();
    it.operation   = rcfe_pkg::OP_FRAME;
    it.data_byte   = b;
    it.frame_start = st;
    return it;
  endfunction

  // well-formed frame with random commands, sometimes cut short or overlong
  task automatic send_frame(input int npairs, ref int sent);
    int         len;
    int         shape;
    int         sort;
    logic [7:0] cmd;
    logic [7:0] val;
    len = 2 * npairs;
    shape = $urandom_range(0, 9);
    if (shape == 0) len = len - 1;
    else if (shape == 1) len = len + 2;
    offer_item(frame_item(8'(len), 1'b1), 1'b0, NO_OUT);
    sent++;
    for (int i = 0; i < npairs; i++) begin
      sort = $urandom_range(0, 9);
      val = 8'($urandom_range(0, 255));
      if (sort < 4) begin
        cmd = {1'b0, 7'($urandom_range(0, 127))};
      end else if (sort < 7) begin
        cmd = rcfe_pkg::READ_FLAG | 8'($urandom_range(0, 127));
      end else begin
        cmd = rcfe_pkg::READ_FLAG |
              ($urandom_range(0, 1) ? rcfe_pkg::IDX_VOLT : rcfe_pkg::IDX_CURR);
        if ($urandom_range(0, 3) != 0) val = 8'($urandom_range(0, 9));
      end
      offer_item(frame_item(cmd, 1'b0), 1'b0, NO_OUT);
      offer_item(frame_item(val, 1'b0), 1'b0, NO_OUT);
      sent += 2;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    rcfe_pkg::out_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      items_out++;
      if (out_ch.payload.write_strobe) strobes_seen++;
      if (out_ch.payload.heartbeat) beats_seen++;
      if (out_ch.payload.reply_last) replies_seen++;
      if (due_outputs.size() == 0) begin
        report_mismatch("item with nothing due", 32'(out_ch.payload), 32'd0);
      end else begin
        want = due_outputs.pop_front();
        if (out_ch.payload.reply_byte != want.reply_byte)
          report_mismatch("reply_byte", 32'(out_ch.payload.reply_byte),
                          32'(want.reply_byte));
        if (out_ch.payload.reply_valid != want.reply_valid)
          report_mismatch("reply_valid", 32'(out_ch.payload.reply_valid),
                          32'(want.reply_valid));
        if (out_ch.payload.reply_last != want.reply_last)
          report_mismatch("reply_last", 32'(out_ch.payload.reply_last),
                          32'(want.reply_last));
        if (out_ch.payload.heartbeat != want.heartbeat)
          report_mismatch("heartbeat", 32'(out_ch.payload.heartbeat),
                          32'(want.heartbeat));
        if (out_ch.payload.write_strobe != want.write_strobe)
          report_mismatch("write_strobe", 32'(out_ch.payload.write_strobe),
                          32'(want.write_strobe));
        if (out_ch.payload.write_index != want.write_index)
          report_mismatch("write_index", 32'(out_ch.payload.write_index),
                          32'(want.write_index));
        if (out_ch.payload.write_value != want.write_value)
          report_mismatch("write_value", 32'(out_ch.payload.write_value),
                          32'(want.write_value));
      end
    end
  end

  // receiver side, with one long hold-off on request
  initial begin : sink_side
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 180;
      end
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= !(idling_on && $urandom_range(0, 99) < 6);
      end
    end
  end

  initial begin : stimulus
    int sent;
    int pick;
    int guard;
    bit hold_done;
    bit big_done;
    rcfe_pkg::in_item_t it;
    sent = 0;
    hold_done = 1'b0;
    big_done = 1'b0;
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    while (sent < RANDOM_ITEMS) begin
      idling_on = !(sent >= 30 && sent < 70);
      if (!hold_done && sent >= 80) begin
        long_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (!big_done || pick < 10) begin
        send_frame(big_done ? $urandom_range(8, 20) : 18, sent);
        big_done = 1'b1;
        offer_item(frame_item(8'h00, 1'b0), 1'b0, NO_OUT);
        sent++;
        it = any_fields();
        it.operation = rcfe_pkg::OP_REPLY;
        offer_item(it, 1'b0, NO_OUT);
        sent++;
      end else if (pick < 55) begin
        send_frame($urandom_range(1, 6), sent);
        if ($urandom_range(0, 9) < 7) begin
          it = any_fields();
          it.operation = rcfe_pkg::OP_REPLY;
          offer_item(it, 1'b0, NO_OUT);
          sent++;
        end
      end else if (pick < 75) begin
        it = any_fields();
        it.operation = $urandom_range(0, 1) ? rcfe_pkg::OP_VOLT : rcfe_pkg::OP_CURR;
        offer_item(it, 1'b0, NO_OUT);
        sent++;
      end else if (pick < 88) begin
        it = any_fields();
        it.operation = rcfe_pkg::OP_REPLY;
        offer_item(it, 1'b0, NO_OUT);
        sent++;
      end else begin
        offer_item(any_fields(), 1'b0, NO_OUT);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;
    idling_on = 1'b1;

    guard = 0;
    while (due_outputs.size() != 0 && guard < 50000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
    if (due_outputs.size() != 0)
      report_mismatch("items never produced", 32'(due_outputs.size()), 32'd0);

    $display("drove %0d items (%0d from the directed table), checked %0d results",
             items_in, DIRECTED_ROWS, items_out);
    $display("  %0d register writes, %0d heartbeats, %0d reply frames, %0d mismatches",
             strobes_seen, beats_seen, replies_seen, err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
